@@ src/mbph_pkg.sv @@
// ----------------------------------------------------------------------------
// mbph_pkg
// Shared types, constants and the permutation table of the multi-byte
// Pearson hash.
// ----------------------------------------------------------------------------
package mbph_pkg;

  typedef logic [7:0] lane_t;

  localparam int LANE_SLOTS             = 8;
  localparam int DEFAULT_MAX_HASH_BYTES = 8;
  localparam int PADDR_W                = 3;
  localparam int PDATA_W                = 32;
  localparam int HASH_LEN_W             = 4;

  localparam logic [HASH_LEN_W-1:0] HASH_LEN_RESET = 4'd8;
  localparam logic [0:0]            REG_HASH_LEN   = 1'b0;

  localparam lane_t PERM [256] = '{
    8'd171, 8'd38,  8'd41,  8'd159, 8'd93,  8'd52,  8'd71,  8'd169,
    8'd246, 8'd73,  8'd191, 8'd232, 8'd196, 8'd33,  8'd13,  8'd34,
    8'd31,  8'd143, 8'd228, 8'd59,  8'd96,  8'd63,  8'd91,  8'd23,
    8'd250, 8'd36,  8'd221, 8'd126, 8'd214, 8'd57,  8'd90,  8'd94,
    8'd157, 8'd58,  8'd88,  8'd213, 8'd29,  8'd4,   8'd83,  8'd179,
    8'd176, 8'd121, 8'd77,  8'd0,   8'd226, 8'd25,  8'd72,  8'd15,
    8'd102, 8'd76,  8'd153, 8'd10,  8'd137, 8'd134, 8'd254, 8'd20,
    8'd128, 8'd65,  8'd198, 8'd89,  8'd229, 8'd47,  8'd160, 8'd12,
    8'd42,  8'd189, 8'd203, 8'd141, 8'd100, 8'd40,  8'd53,  8'd78,
    8'd182, 8'd35,  8'd130, 8'd68,  8'd197, 8'd212, 8'd55,  8'd111,
    8'd18,  8'd194, 8'd131, 8'd252, 8'd22,  8'd125, 8'd147, 8'd124,
    8'd39,  8'd11,  8'd21,  8'd174, 8'd249, 8'd97,  8'd209, 8'd144,
    8'd218, 8'd27,  8'd82,  8'd5,   8'd220, 8'd67,  8'd129, 8'd150,
    8'd92,  8'd193, 8'd48,  8'd45,  8'd139, 8'd216, 8'd255, 8'd110,
    8'd140, 8'd156, 8'd192, 8'd87,  8'd215, 8'd69,  8'd185, 8'd104,
    8'd175, 8'd181, 8'd109, 8'd75,  8'd231, 8'd138, 8'd180, 8'd105,
    8'd6,   8'd80,  8'd54,  8'd190, 8'd135, 8'd227, 8'd50,  8'd164,
    8'd146, 8'd8,   8'd148, 8'd115, 8'd123, 8'd32,  8'd206, 8'd7,
    8'd238, 8'd74,  8'd204, 8'd223, 8'd177, 8'd248, 8'd149, 8'd188,
    8'd230, 8'd239, 8'd170, 8'd51,  8'd61,  8'd30,  8'd24,  8'd98,
    8'd28,  8'd1,   8'd37,  8'd200, 8'd46,  8'd184, 8'd244, 8'd113,
    8'd116, 8'd154, 8'd84,  8'd86,  8'd199, 8'd112, 8'd133, 8'd107,
    8'd145, 8'd207, 8'd241, 8'd166, 8'd162, 8'd101, 8'd172, 8'd208,
    8'd205, 8'd236, 8'd211, 8'd106, 8'd19,  8'd132, 8'd225, 8'd56,
    8'd108, 8'd99,  8'd186, 8'd9,   8'd251, 8'd183, 8'd210, 8'd114,
    8'd245, 8'd242, 8'd187, 8'd62,  8'd165, 8'd60,  8'd127, 8'd17,
    8'd161, 8'd64,  8'd3,   8'd234, 8'd237, 8'd16,  8'd168, 8'd152,
    8'd120, 8'd95,  8'd167, 8'd155, 8'd49,  8'd219, 8'd81,  8'd202,
    8'd122, 8'd26,  8'd136, 8'd44,  8'd70,  8'd224, 8'd79,  8'd117,
    8'd201, 8'd253, 8'd222, 8'd103, 8'd233, 8'd2,   8'd243, 8'd178,
    8'd235, 8'd240, 8'd66,  8'd119, 8'd173, 8'd195, 8'd163, 8'd85,
    8'd247, 8'd151, 8'd158, 8'd142, 8'd43,  8'd14,  8'd217, 8'd118
  };

  function automatic lane_t perm(input lane_t x);
    return PERM[x];
  endfunction

endpackage

@@ src/mbph_lane.sv @@
// ----------------------------------------------------------------------------
// mbph_lane
// Next value of one hash lane: optional seed load, offset xor, table lookup.
// ----------------------------------------------------------------------------
module mbph_lane #(
  parameter int LANE_IDX = 0
) (
  input  mbph_pkg::lane_t lane,
  input  mbph_pkg::lane_t seed_byte,
  input  mbph_pkg::lane_t data_byte,
  input  logic            first_byte,
  output mbph_pkg::lane_t lane_next
);
  import mbph_pkg::*;

  lane_t start;
  lane_t offset;

  always_comb begin
    start     = first_byte ? seed_byte : lane;
    offset    = data_byte + lane_t'(LANE_IDX);
    lane_next = perm(start ^ offset);
  end

endmodule

@@ src/multi_byte_pearson_hash.sv @@
// ----------------------------------------------------------------------------
// multi_byte_pearson_hash
// Multi-byte Pearson hash with up to eight parallel lanes.
// ----------------------------------------------------------------------------
// One message byte is taken per cycle while data_ready is high. A word is held
// in an input register, all lanes are updated from it in one table lookup
// each, and on the last byte the hash goes to the output register that drives
// hash_valid. A full output register stalls only a word that carries
// last_byte. first_byte loads lane j from seed byte j before the
// update. hash_len (APB address 0, reset 8) selects how many bytes are
// output; 0 acts as 1, values above MAX_HASH_BYTES act as MAX_HASH_BYTES,
// unused bytes read as zero.
// ----------------------------------------------------------------------------
module multi_byte_pearson_hash #(
  parameter int MAX_HASH_BYTES = mbph_pkg::DEFAULT_MAX_HASH_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mbph_pkg::PADDR_W-1:0]  paddr,
  input  logic [mbph_pkg::PDATA_W-1:0]  pwdata,
  output logic [mbph_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          data_valid,
  output logic                          data_ready,
  input  logic [7:0]                    data_byte,
  input  logic                          first_byte,
  input  logic                          last_byte,
  input  logic [63:0]                   seed,
  output logic                          hash_valid,
  input  logic                          hash_ready,
  output logic [63:0]                   hash_value
);
  import mbph_pkg::*;

  logic [HASH_LEN_W-1:0] hash_len;
  logic [HASH_LEN_W-1:0] active_len;

  logic        word_valid;
  lane_t       word_byte;
  logic        word_first;
  logic        word_last;
  logic [63:0] word_seed;
  logic        advance;

  lane_t       lanes      [MAX_HASH_BYTES];
  lane_t       lanes_next [MAX_HASH_BYTES];
  logic [63:0] hash_next;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_len <= HASH_LEN_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_HASH_LEN) begin
      hash_len <= pwdata[HASH_LEN_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_HASH_LEN) begin
      prdata = {{(PDATA_W-HASH_LEN_W){1'b0}}, hash_len};
    end else begin
      prdata = '0;
    end
  end

  always_comb begin
    priority if (hash_len == '0) begin
      active_len = HASH_LEN_W'(1);
    end else if (hash_len > HASH_LEN_W'(MAX_HASH_BYTES)) begin
      active_len = HASH_LEN_W'(MAX_HASH_BYTES);
    end else begin
      active_len = hash_len;
    end
  end

  // a word without last_byte never needs the output register
  assign advance    = word_valid && (!word_last || !hash_valid || hash_ready);
  assign data_ready = !word_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (data_ready) begin
      word_valid <= data_valid;
    end
    if (data_ready && data_valid) begin
      word_byte  <= data_byte;
      word_first <= first_byte;
      word_last  <= last_byte;
      word_seed  <= seed;
    end
  end

  for (genvar j = 0; j < MAX_HASH_BYTES; j++) begin : g_lane
    mbph_lane #(
      .LANE_IDX(j)
    ) u_lane (
      .lane      (lanes[j]),
      .seed_byte (word_seed[8*j +: 8]),
      .data_byte (word_byte),
      .first_byte(word_first),
      .lane_next (lanes_next[j])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        lanes[j] <= '0;
      end else if (advance) begin
        lanes[j] <= lanes_next[j];
      end
    end
  end

  for (genvar j = 0; j < LANE_SLOTS; j++) begin : g_out
    if (j < MAX_HASH_BYTES) begin : g_used
      assign hash_next[8*j +: 8] =
        (HASH_LEN_W'(j) < active_len) ? lanes_next[j] : 8'h00;
    end else begin : g_unused
      assign hash_next[8*j +: 8] = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_valid <= 1'b0;
    end else if (advance && word_last) begin
      hash_valid <= 1'b1;
    end else if (hash_ready) begin
      hash_valid <= 1'b0;
    end
    if (advance && word_last) begin
      hash_value <= hash_next;
    end
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-byte Pearson hash.
// ----------------------------------------------------------------------------
// A queue of message bytes feeds a valid/ready driver, and a scoreboard model
// of the eight hash lanes predicts each hash word. A monitor compares every
// accepted hash word with the oldest prediction. hash_len is written over APB
// between phases, including the out-of-range values and a change in the
// middle of a message. Random traffic is mostly well-formed messages, with
// unseeded continuations and random flag noise mixed in. Both sides idle at
// random, and one phase holds off the receiver long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_top;
  import mbph_pkg::*;

  localparam int LANES        = DEFAULT_MAX_HASH_BYTES;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 6;
  localparam int PRINT_CAP    = 40;
  localparam logic [PADDR_W-1:0] HASH_LEN_ADDR = PADDR_W'(4 * REG_HASH_LEN);

  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [63:0] seed;
  } msg_word_t;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               psel       = 1'b0;
  logic               penable    = 1'b0;
  logic               pwrite     = 1'b0;
  logic [PADDR_W-1:0] paddr      = '0;
  logic [PDATA_W-1:0] pwdata     = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               data_valid = 1'b0;
  logic               data_ready;
  logic [7:0]         data_byte  = '0;
  logic               first_byte = 1'b0;
  logic               last_byte  = 1'b0;
  logic [63:0]        seed       = '0;
  logic               hash_valid;
  logic               hash_ready = 1'b0;
  logic [63:0]        hash_value;

  // scoreboard model state
  lane_t                 lane_state [LANES];
  logic [HASH_LEN_W-1:0] hash_len_cfg = HASH_LEN_RESET;
  logic [63:0]           expected_hashes [$];
  msg_word_t             pending_bytes [$];

  int bytes_queued   = 0;
  int bytes_accepted = 0;
  int hashes_checked = 0;
  int cfg_writes     = 0;
  int mismatches     = 0;
  int cycles         = 0;

  // idling controls, set per phase
  bit tx_idle_on  = 1'b1;
  bit rx_idle_on  = 1'b1;
  bit hold_req    = 1'b0;
  int tx_gap      = 0;
  int rx_wait     = 0;
  int hold_left   = 0;

  multi_byte_pearson_hash dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .data_valid (data_valid),
    .data_ready (data_ready),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .last_byte  (last_byte),
    .seed       (seed),
    .hash_valid (hash_valid),
    .hash_ready (hash_ready),
    .hash_value (hash_value)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("[%0d] mismatch: %s", cycles, msg);
    end
  endtask

  function automatic int active_lanes();
    if (hash_len_cfg == 0) return 1;
    if (int'(hash_len_cfg) > LANES) return LANES;
    return int'(hash_len_cfg);
  endfunction

  // advance all lanes by one message byte, predict a hash word on last
  task automatic absorb_byte(input msg_word_t w);
    lane_t       start;
    lane_t       idx;
    logic [63:0] h;
    h = '0;
    for (int j = 0; j < LANES; j++) begin
      start = w.first ? w.seed[8*j +: 8] : lane_state[j];
      idx = start ^ (w.data + 8'(j));
      lane_state[j] = PERM[idx];
    end
    if (w.last) begin
      for (int j = 0; j < active_lanes(); j++) begin
        h[8*j +: 8] = lane_state[j];
      end
      expected_hashes.push_back(h);
    end
  endtask

  function automatic logic [63:0] rand_seed();
    return {$urandom, $urandom};
  endfunction

  task automatic push_word(input logic [7:0] d, input logic f, input logic l,
                           input logic [63:0] s);
    msg_word_t w;
    w.data = d;
    w.first = f;
    w.last = l;
    w.seed = s;
    pending_bytes.push_back(w);
    bytes_queued++;
  endtask

  task automatic queue_message(input int len, input bit seeded);
    for (int k = 0; k < len; k++) begin
      push_word(8'($urandom), seeded && k == 0, k == len - 1, rand_seed());
    end
  endtask

  task automatic fill_random(input int n);
    int made;
    int r;
    int len;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      if (r < 78) begin
        queue_message(len, 1'b1);
      end else if (r < 88) begin
        queue_message(len, 1'b0);
      end else begin
        len = len % 6 + 1;
        for (int k = 0; k < len; k++) begin
          push_word(8'($urandom), 1'($urandom), 1'($urandom), rand_seed());
        end
      end
      made += len;
    end
  endtask

  // wait until every byte is taken and every hash word is back
  task automatic settle();
    int waited;
    waited = 0;
    while ((bytes_accepted != bytes_queued || expected_hashes.size() != 0)
           && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (bytes_accepted != bytes_queued) begin
      report_mismatch($sformatf("%0d bytes never accepted", bytes_queued - bytes_accepted));
    end
    if (expected_hashes.size() != 0) begin
      report_mismatch($sformatf("%0d hash words never arrived", expected_hashes.size()));
      expected_hashes.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_hash_len(input logic [PDATA_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= HASH_LEN_ADDR;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    hash_len_cfg = v[HASH_LEN_W-1:0];
    cfg_writes++;
  endtask

  // byte driver
  always @(posedge clk) begin
    msg_word_t w;
    if (rst) begin
      data_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (data_valid && data_ready) begin
        absorb_byte('{data_byte, first_byte, last_byte, seed});
        bytes_accepted++;
      end
      if (!data_valid || data_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          data_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          w = pending_bytes.pop_front();
          data_byte  <= w.data;
          first_byte <= w.first;
          last_byte  <= w.last;
          seed       <= w.seed;
          data_valid <= 1'b1;
          tx_gap = tx_idle_on ? $urandom_range(0, 4) : 0;
        end else begin
          data_valid <= 1'b0;
        end
      end
    end
  end

  // hash receiver
  always @(posedge clk) begin
    if (rst) begin
      hash_ready <= 1'b0;
      rx_wait = 0;
      hold_left = 0;
    end else begin
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (hash_valid && hash_ready) begin
        rx_wait = rx_idle_on ? $urandom_range(0, 4) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        hash_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        hash_ready <= 1'b0;
      end else begin
        hash_ready <= 1'b1;
      end
    end
  end

  // hash monitor
  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst && hash_valid && hash_ready) begin
      if (expected_hashes.size() == 0) begin
        report_mismatch($sformatf("unexpected hash word %h", hash_value));
      end else begin
        want = expected_hashes.pop_front();
        hashes_checked++;
        if (hash_value !== want) begin
          report_mismatch($sformatf("hash_value %h, expected %h", hash_value, want));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("run stopped at cycle limit, %0d of %0d bytes accepted",
               bytes_accepted, bytes_queued);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [PDATA_W-1:0] v;
    for (int j = 0; j < LANES; j++) lane_state[j] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset lanes with no seed, then one-byte messages at the extremes, a three-byte message and an unterminated one
    push_word(8'h00, 1'b0, 1'b0, '0);
    push_word(8'hff, 1'b0, 1'b1, '0);
    push_word(8'h00, 1'b1, 1'b1, 64'h0);
    push_word(8'hff, 1'b1, 1'b1, '1);
    push_word(8'($urandom), 1'b1, 1'b1, rand_seed());
    push_word(8'h80, 1'b1, 1'b0, 64'hff00ff00_00ff00ff);
    push_word(8'h7f, 1'b0, 1'b0, '0);
    push_word(8'h01, 1'b0, 1'b1, '1);
    push_word(8'h5a, 1'b1, 1'b0, rand_seed());
    push_word(8'ha5, 1'b0, 1'b0, rand_seed());
    settle();

    // length drops to one in the middle of a message
    write_hash_len(32'h0);
    push_word(8'h3c, 1'b0, 1'b1, rand_seed());
    push_word(8'($urandom), 1'b1, 1'b1, rand_seed());
    settle();

    // reseed inside a message
    write_hash_len(32'hf);
    push_word(8'($urandom), 1'b1, 1'b0, rand_seed());
    push_word(8'($urandom), 1'b1, 1'b0, rand_seed());
    push_word(8'($urandom), 1'b0, 1'b1, rand_seed());
    push_word(8'h00, 1'b1, 1'b1, 64'h8000_0000_0000_0001);
    settle();

    write_hash_len(32'h9);
    push_word(8'hff, 1'b1, 1'b1, '1);
    settle();

    write_hash_len(32'h1);
    push_word(8'($urandom), 1'b1, 1'b0, rand_seed());
    push_word(8'($urandom), 1'b0, 1'b1, rand_seed());
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      v = $urandom;
      case (ph)
        0: v[HASH_LEN_W-1:0] = 4'd8;
        1: v[HASH_LEN_W-1:0] = 4'd1;
        default: ;
      endcase
      write_hash_len(v);
      tx_idle_on = (ph != 2) && ($urandom_range(0, 3) != 0);
      rx_idle_on = (ph != 2) && ($urandom_range(0, 3) != 0);
      if (ph == 4) begin
        tx_idle_on = 1'b0;
        hold_req = 1'b1;
      end
      fill_random(80);
      settle();
    end

    $display("%0d message bytes accepted, %0d hash words checked", bytes_accepted,
             hashes_checked);
    $display("%0d hash_len writes, one long output stall", cfg_writes);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
